/* design/wft_pkg.sv */
// Shared types for the word frequency table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wft_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LEN_CHK,
        ST_BYTE_RD,
        ST_BYTE_CHK,
        ST_CNT_RD,
        ST_CNT_UPD,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_INS_FIN,
        ST_DROP
    } wft_state_t;

    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UZ = 8'h5A;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LZ = 8'h7A;

endpackage
`default_nettype wire

/* design/word_frequency_table.sv */
// Word frequency table: byte stream in, one result per closed word out.
// A byte that closes no word leaves the block idle and ready for the next byte; a
// closing byte starts a scan of the stored entries, with a byte compare of each
// length-matching key in the single-port key store and a byte copy on insert.
// Reset: counters and lengths clear; memories hold undefined data until written.
// Depends on wft_pkg.
`timescale 1ns / 1ps
`default_nettype none
module word_frequency_table #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_WORD_LEN  = 79,
    parameter int COUNT_WIDTH   = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_code,
    input  wire logic        end_of_text,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       entry_index,
    output logic [31:0]      word_occurrences,
    output logic             is_new,
    output logic             dropped_full,
    output logic             truncated,
    output logic [31:0]      total_words,
    output logic [8:0]       unique_words
);
    import wft_pkg::*;

    localparam int KEY_DEPTH = TABLE_ENTRIES * MAX_WORD_LEN;
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int EW = $clog2(TABLE_ENTRIES + 1);
    localparam int BW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int LW = $clog2(MAX_WORD_LEN + 1);
    localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_WORD_LEN);
    localparam logic [EW-1:0] ENT_MAX = EW'(TABLE_ENTRIES);
    localparam logic [AW-1:0] BASE_STEP = AW'(MAX_WORD_LEN);

    logic [7:0]             wbuf_mem [MAX_WORD_LEN];
    logic [7:0]             key_mem  [KEY_DEPTH];
    logic [LW-1:0]          klen_mem [TABLE_ENTRIES];
    logic [COUNT_WIDTH-1:0] cnt_mem  [TABLE_ENTRIES];

    logic [7:0]             wbuf_q, key_q;
    logic [LW-1:0]          klen_q;
    logic [COUNT_WIDTH-1:0] cnt_q;

    wft_state_t state_reg, state_next;
    logic [LW-1:0]          len_reg, len_next;
    logic                   ovf_reg, ovf_next;
    logic [EW-1:0]          e_reg, e_next;
    logic [EW-1:0]          occ_reg, occ_next;
    logic [AW-1:0]          base_reg, base_next;
    logic [BW-1:0]          j_reg, j_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;

    logic                   ov_reg, ov_next;
    logic [7:0]             oidx_reg, oidx_next;
    logic [COUNT_WIDTH-1:0] ocnt_reg, ocnt_next;
    logic                   onew_reg, onew_next;
    logic                   odrop_reg, odrop_next;
    logic                   otrunc_reg, otrunc_next;
    logic [COUNT_WIDTH-1:0] ototal_reg, ototal_next;
    logic [EW-1:0]          ouniq_reg, ouniq_next;

    logic                   accept, letter, close_word, out_free, last_byte;
    logic [LW-1:0]          len_new;
    logic                   wbuf_we, key_we, klen_we, cnt_we;
    logic [IW-1:0]          ent_addr, ins_addr;
    logic [AW-1:0]          key_addr;
    logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_inc, total_inc;

    assign accept = in_valid && in_ready;
    assign letter = (char_code >= CH_0 && char_code <= CH_9) ||
                    (char_code >= CH_UA && char_code <= CH_UZ) ||
                    (char_code >= CH_LA && char_code <= CH_LZ);
    assign len_new = (letter && len_reg < LEN_MAX) ? len_reg + LW'(1) : len_reg;
    assign close_word = (!letter || end_of_text) && (len_new != '0);
    assign out_free = !ov_reg || out_ready;
    assign last_byte = (LW'(j_reg) == len_reg - LW'(1));
    assign ent_addr = IW'(e_reg);
    assign ins_addr = IW'(occ_reg);
    assign key_addr = base_reg + AW'(j_reg);
    assign cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
    assign total_inc = (total_reg == CNT_MAX) ? total_reg : total_reg + COUNT_WIDTH'(1);

    always_ff @(posedge clk)
    begin
        if (wbuf_we)
        begin
            wbuf_mem[len_reg[BW-1:0]] <= char_code;
        end
        wbuf_q <= wbuf_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_addr] <= wbuf_q;
        end
        key_q <= key_mem[key_addr];
    end

    always_ff @(posedge clk)
    begin
        if (klen_we)
        begin
            klen_mem[ins_addr] <= len_reg;
        end
        klen_q <= klen_mem[ent_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[(state_reg == ST_INS_FIN) ? ins_addr : ent_addr] <= cnt_wdata;
        end
        cnt_q <= cnt_mem[ent_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && close_word)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (e_reg != occ_reg)
                begin
                    state_next = ST_LEN_CHK;
                end
                else if (occ_reg == ENT_MAX)
                begin
                    state_next = ST_DROP;
                end
                else
                begin
                    state_next = ST_COPY_RD;
                end
            end
            ST_LEN_CHK:
            begin
                state_next = (klen_q == len_reg) ? ST_BYTE_RD : ST_SCAN;
            end
            ST_BYTE_RD:
            begin
                state_next = ST_BYTE_CHK;
            end
            ST_BYTE_CHK:
            begin
                if (key_q != wbuf_q)
                begin
                    state_next = ST_SCAN;
                end
                else if (last_byte)
                begin
                    state_next = ST_CNT_RD;
                end
                else
                begin
                    state_next = ST_BYTE_RD;
                end
            end
            ST_CNT_RD:
            begin
                state_next = ST_CNT_UPD;
            end
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                state_next = last_byte ? ST_INS_FIN : ST_COPY_RD;
            end
            ST_CNT_UPD, ST_INS_FIN, ST_DROP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        e_next      = e_reg;
        occ_next    = occ_reg;
        base_next   = base_reg;
        j_next      = j_reg;
        total_next  = total_reg;
        ov_next     = ov_reg && !out_ready;
        oidx_next   = oidx_reg;
        ocnt_next   = ocnt_reg;
        onew_next   = onew_reg;
        odrop_next  = odrop_reg;
        otrunc_next = otrunc_reg;
        ototal_next = ototal_reg;
        ouniq_next  = ouniq_reg;
        wbuf_we     = 1'b0;
        key_we      = 1'b0;
        klen_we     = 1'b0;
        cnt_we      = 1'b0;
        cnt_wdata   = cnt_inc;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    wbuf_we  = letter && (len_reg < LEN_MAX);
                    len_next = len_new;
                    ovf_next = ovf_reg || (letter && len_reg == LEN_MAX);
                    e_next   = '0;
                    base_next = '0;
                end
            end
            ST_LEN_CHK:
            begin
                j_next = '0;
                if (klen_q != len_reg)
                begin
                    e_next    = e_reg + EW'(1);
                    base_next = base_reg + BASE_STEP;
                end
            end
            ST_SCAN:
            begin
                j_next = '0;
            end
            ST_BYTE_CHK:
            begin
                if (key_q != wbuf_q)
                begin
                    e_next    = e_reg + EW'(1);
                    base_next = base_reg + BASE_STEP;
                end
                else if (!last_byte)
                begin
                    j_next = j_reg + BW'(1);
                end
            end
            ST_COPY_WR:
            begin
                key_we = 1'b1;
                if (!last_byte)
                begin
                    j_next = j_reg + BW'(1);
                end
            end
            ST_CNT_UPD, ST_INS_FIN, ST_DROP:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    otrunc_next = ovf_reg;
                    len_next    = '0;
                    ovf_next    = 1'b0;
                    onew_next   = (state_reg == ST_INS_FIN);
                    odrop_next  = (state_reg == ST_DROP);
                    if (state_reg == ST_DROP)
                    begin
                        oidx_next   = '0;
                        ocnt_next   = '0;
                        ototal_next = total_reg;
                        ouniq_next  = occ_reg;
                    end
                    else if (state_reg == ST_CNT_UPD)
                    begin
                        cnt_we      = 1'b1;
                        oidx_next   = 8'(e_reg);
                        ocnt_next   = cnt_inc;
                        total_next  = total_inc;
                        ototal_next = total_inc;
                        ouniq_next  = occ_reg;
                    end
                    else
                    begin
                        cnt_we      = 1'b1;
                        cnt_wdata   = COUNT_WIDTH'(1);
                        klen_we     = 1'b1;
                        oidx_next   = 8'(occ_reg);
                        ocnt_next   = COUNT_WIDTH'(1);
                        occ_next    = occ_reg + EW'(1);
                        total_next  = total_inc;
                        ototal_next = total_inc;
                        ouniq_next  = occ_reg + EW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            e_reg     <= '0;
            occ_reg   <= '0;
            base_reg  <= '0;
            j_reg     <= '0;
            total_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            e_reg     <= e_next;
            occ_reg   <= occ_next;
            base_reg  <= base_next;
            j_reg     <= j_next;
            total_reg <= total_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oidx_reg   <= oidx_next;
        ocnt_reg   <= ocnt_next;
        onew_reg   <= onew_next;
        odrop_reg  <= odrop_next;
        otrunc_reg <= otrunc_next;
        ototal_reg <= ototal_next;
        ouniq_reg  <= ouniq_next;
    end

    assign out_valid        = ov_reg;
    assign entry_index      = oidx_reg;
    assign word_occurrences = 32'(ocnt_reg);
    assign is_new           = onew_reg;
    assign dropped_full     = odrop_reg;
    assign truncated        = otrunc_reg;
    assign total_words      = 32'(ototal_reg);
    assign unique_words     = 9'(ouniq_reg);

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= ENT_MAX)
        else $error("occupied count exceeds table size");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (e_reg <= occ_reg))
        else $error("scan index beyond occupied entries");
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_MAX)
        else $error("word length beyond maximum");
    a_new_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_new && dropped_full))
        else $error("result both new and dropped");
    a_close_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (len_reg != '0))
        else $error("search started on empty word");

endmodule
`default_nettype wire
